// ===== rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared types and constants: scan modes, token kinds, error codes.
// ----------------------------------------------------------------------------
package stt_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_HASH1, M_LINE, M_OPEN, M_BODY, M_CLOSE, M_IDENT, M_BUILTIN,
        M_NUMBER, M_NUMDOT, M_FRAC, M_STRING, M_MINUS, M_DOT
    } mode_t;

    localparam logic [5:0] K_LPAREN    = 6'd0;
    localparam logic [5:0] K_RPAREN    = 6'd1;
    localparam logic [5:0] K_LBRACE    = 6'd2;
    localparam logic [5:0] K_RBRACE    = 6'd3;
    localparam logic [5:0] K_COMMA     = 6'd4;
    localparam logic [5:0] K_SEMICOLON = 6'd5;
    localparam logic [5:0] K_DOT       = 6'd6;
    localparam logic [5:0] K_COLON     = 6'd7;
    localparam logic [5:0] K_EQUAL     = 6'd8;
    localparam logic [5:0] K_ARROW     = 6'd9;
    localparam logic [5:0] K_AMP       = 6'd10;
    localparam logic [5:0] K_STAR      = 6'd11;
    localparam logic [5:0] K_PLUS      = 6'd12;
    localparam logic [5:0] K_MINUS     = 6'd13;
    localparam logic [5:0] K_SLASH     = 6'd14;
    localparam logic [5:0] K_PERCENT   = 6'd15;
    localparam logic [5:0] K_DOTSTAR   = 6'd16;
    localparam logic [5:0] K_IDENT     = 6'd17;
    localparam logic [5:0] K_BUILTIN   = 6'd18;
    localparam logic [5:0] K_STRING    = 6'd19;
    localparam logic [5:0] K_NUMBER    = 6'd20;
    localparam logic [5:0] K_ERROR     = 6'd44;
    localparam logic [5:0] K_END       = 6'd45;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_BADCHAR = 3'd1;
    localparam logic [2:0] E_STRING  = 3'd2;
    localparam logic [2:0] E_DOT     = 3'd3;
    localparam logic [2:0] E_COMMENT = 3'd4;

    localparam int KW_COUNT = 22;
    localparam int KW_CHARS = 8;

    // Keyword text, first character in the low byte, zero padded
    function automatic logic [63:0] kw_text(input logic [4:0] i);
        logic [63:0] t;
        case (i)
            5'd0:    t = 64'h6E7566;
            5'd1:    t = 64'h6669;
            5'd2:    t = 64'h65736C65;
            5'd3:    t = 64'h726F66;
            5'd4:    t = 64'h6E7275746572;
            5'd5:    t = 64'h6B61657262;
            5'd6:    t = 64'h65756E69746E6F63;
            5'd7:    t = 64'h6C6176;
            5'd8:    t = 64'h726176;
            5'd9:    t = 64'h65707974;
            5'd10:   t = 64'h646E61;
            5'd11:   t = 64'h726F;
            5'd12:   t = 64'h3869;
            5'd13:   t = 64'h363169;
            5'd14:   t = 64'h323369;
            5'd15:   t = 64'h343669;
            5'd16:   t = 64'h3875;
            5'd17:   t = 64'h363175;
            5'd18:   t = 64'h323375;
            5'd19:   t = 64'h343675;
            5'd20:   t = 64'h323366;
            5'd21:   t = 64'h343666;
            default: t = 64'h0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input logic [4:0] i);
        logic [3:0] n;
        case (i)
            5'd1, 5'd11, 5'd12, 5'd16:  n = 4'd2;
            5'd2, 5'd9:                 n = 4'd4;
            5'd4:                       n = 4'd6;
            5'd5:                       n = 4'd5;
            5'd6:                       n = 4'd8;
            default:                    n = 4'd3;
        endcase
        return n;
    endfunction

    // One token as it travels from the scanner to the output stage
    typedef struct packed {
        logic [5:0] kind;
        logic [2:0] err;
        logic       last;
    } tok_ctl_t;

endpackage

// ===== rtl/stt_front.sv =====
// ----------------------------------------------------------------------------
// Tokenizer front end
// Scans one byte a cycle while step is high and forms up to two tokens per byte.
// ----------------------------------------------------------------------------
module stt_front #(
    parameter int OFFSET_BITS = 24,
    parameter int LINE_BITS   = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             char_byte,
    input  logic                   end_marker,
    output logic [1:0]             n_tok,
    output stt_pkg::tok_ctl_t      ctl0,
    output logic [OFFSET_BITS-1:0] start0,
    output logic [OFFSET_BITS-1:0] len0,
    output stt_pkg::tok_ctl_t      ctl1,
    output logic [OFFSET_BITS-1:0] start1,
    output logic [OFFSET_BITS-1:0] len1,
    output logic [LINE_BITS-1:0]   line_a,
    output logic [LINE_BITS-1:0]   line_b
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LN_MAX  = '1;

    stt_pkg::mode_t          mode_reg, mode_next;
    logic [OFFSET_BITS-1:0]  pos_reg, begin_reg, begin_next;
    logic [LINE_BITS-1:0]    line_reg, line_next;
    logic [63:0]             word_reg, word_next;
    logic [7:0]              open_reg, open_next, close_reg, close_next;

    logic [OFFSET_BITS-1:0]  lb, lw;
    logic                    alpha, digit, wordc;
    logic [5:0]              kw_kind;

    always_comb
    begin
        lb = (pos_reg >= begin_reg) ? pos_reg - begin_reg : '0;
        lw = (lb == OFF_MAX) ? OFF_MAX : lb + 1'b1;
        alpha = (char_byte >= 8'h41 && char_byte <= 8'h5A) ||
                (char_byte >= 8'h61 && char_byte <= 8'h7A) || char_byte == 8'h5F;
        digit = char_byte >= 8'h30 && char_byte <= 8'h39;
        wordc = alpha || digit;
    end

    always_comb
    begin
        kw_kind = stt_pkg::K_IDENT;
        for (int i = stt_pkg::KW_COUNT - 1; i >= 0; i--)
        begin
            if (lb == OFFSET_BITS'(stt_pkg::kw_len(5'(i))) &&
                word_reg == stt_pkg::kw_text(5'(i)))
                kw_kind = 6'(21 + i);
        end
    end

    // Token slots: a flushed token goes first, then the byte's own
    logic                   e0, e1;
    stt_pkg::tok_ctl_t      c0, c1;
    logic [OFFSET_BITS-1:0] s0, l0, s1, l1;
    logic                   idle_go;
    logic                   nl_first;

    always_comb
    begin
        mode_next  = mode_reg;
        begin_next = begin_reg;
        line_next  = line_reg;
        word_next  = word_reg;
        open_next  = open_reg;
        close_next = close_reg;
        e0 = 1'b0; e1 = 1'b0;
        c0 = '0; c1 = '0;
        s0 = begin_reg; l0 = lb; s1 = pos_reg; l1 = OFFSET_BITS'(1);
        idle_go = 1'b0;
        nl_first = 1'b0;
        if (end_marker)
        begin
            e0 = 1'b1;
            unique case (mode_reg)
                stt_pkg::M_IDENT:   c0.kind = kw_kind;
                stt_pkg::M_BUILTIN: c0.kind = stt_pkg::K_BUILTIN;
                stt_pkg::M_NUMBER, stt_pkg::M_FRAC: c0.kind = stt_pkg::K_NUMBER;
                stt_pkg::M_NUMDOT:
                begin
                    c0.kind = stt_pkg::K_ERROR; c0.err = stt_pkg::E_DOT;
                end
                stt_pkg::M_STRING:
                begin
                    c0.kind = stt_pkg::K_ERROR; c0.err = stt_pkg::E_STRING;
                end
                stt_pkg::M_MINUS:   c0.kind = stt_pkg::K_MINUS;
                stt_pkg::M_DOT:     c0.kind = stt_pkg::K_DOT;
                stt_pkg::M_OPEN, stt_pkg::M_BODY:
                begin
                    c0.kind = stt_pkg::K_ERROR; c0.err = stt_pkg::E_COMMENT;
                end
                stt_pkg::M_CLOSE:
                begin
                    c0.kind = stt_pkg::K_ERROR; c0.err = stt_pkg::E_COMMENT;
                    e0 = close_reg != open_reg;
                end
                default: e0 = 1'b0;
            endcase
            e1 = 1'b1;
            c1.kind = stt_pkg::K_END;
            l1 = '0;
            mode_next = stt_pkg::M_IDLE;
        end
        else
        begin
            unique case (mode_reg)
                stt_pkg::M_HASH1:
                    if (char_byte == 8'h23)
                    begin
                        open_next = 8'd2; mode_next = stt_pkg::M_OPEN;
                    end
                    else if (char_byte == 8'h0A) idle_go = 1'b1;
                    else mode_next = stt_pkg::M_LINE;
                stt_pkg::M_LINE:
                    if (char_byte == 8'h0A) idle_go = 1'b1;
                stt_pkg::M_OPEN:
                    if (char_byte == 8'h23)
                    begin
                        if (open_reg != 8'hFF) open_next = open_reg + 8'd1;
                    end
                    else
                    begin
                        mode_next = stt_pkg::M_BODY;
                        nl_first = char_byte == 8'h0A;
                    end
                stt_pkg::M_BODY:
                    if (char_byte == 8'h23)
                    begin
                        close_next = 8'd1; mode_next = stt_pkg::M_CLOSE;
                    end
                    else nl_first = char_byte == 8'h0A;
                stt_pkg::M_CLOSE:
                    if (char_byte == 8'h23)
                    begin
                        if (close_reg != 8'hFF) close_next = close_reg + 8'd1;
                    end
                    else if (close_reg == open_reg) idle_go = 1'b1;
                    else
                    begin
                        mode_next = stt_pkg::M_BODY;
                        nl_first = char_byte == 8'h0A;
                    end
                stt_pkg::M_IDENT:
                    if (wordc)
                    begin
                        if (lb < OFFSET_BITS'(stt_pkg::KW_CHARS))
                            word_next = word_reg |
                                (64'(char_byte) << {lb[2:0], 3'b000});
                    end
                    else
                    begin
                        e0 = 1'b1; c0.kind = kw_kind; idle_go = 1'b1;
                    end
                stt_pkg::M_BUILTIN:
                    if (!wordc)
                    begin
                        e0 = 1'b1; c0.kind = stt_pkg::K_BUILTIN; idle_go = 1'b1;
                    end
                stt_pkg::M_NUMBER:
                    if (char_byte == 8'h2E) mode_next = stt_pkg::M_NUMDOT;
                    else if (!digit)
                    begin
                        e0 = 1'b1; c0.kind = stt_pkg::K_NUMBER; idle_go = 1'b1;
                    end
                stt_pkg::M_NUMDOT:
                    if (digit) mode_next = stt_pkg::M_FRAC;
                    else
                    begin
                        e0 = 1'b1; c0.kind = stt_pkg::K_ERROR;
                        c0.err = stt_pkg::E_DOT; idle_go = 1'b1;
                    end
                stt_pkg::M_FRAC:
                    if (!digit)
                    begin
                        e0 = 1'b1; c0.kind = stt_pkg::K_NUMBER; idle_go = 1'b1;
                    end
                stt_pkg::M_STRING:
                    if (char_byte == 8'h22)
                    begin
                        e0 = 1'b1; c0.kind = stt_pkg::K_STRING; l0 = lw;
                        mode_next = stt_pkg::M_IDLE;
                    end
                    else nl_first = char_byte == 8'h0A;
                stt_pkg::M_MINUS:
                    if (char_byte == 8'h3E)
                    begin
                        e0 = 1'b1; c0.kind = stt_pkg::K_ARROW; l0 = lw;
                        mode_next = stt_pkg::M_IDLE;
                    end
                    else
                    begin
                        e0 = 1'b1; c0.kind = stt_pkg::K_MINUS; idle_go = 1'b1;
                    end
                stt_pkg::M_DOT:
                    if (char_byte == 8'h2A)
                    begin
                        e0 = 1'b1; c0.kind = stt_pkg::K_DOTSTAR; l0 = lw;
                        mode_next = stt_pkg::M_IDLE;
                    end
                    else
                    begin
                        e0 = 1'b1; c0.kind = stt_pkg::K_DOT; idle_go = 1'b1;
                    end
                default: idle_go = 1'b1;
            endcase

            if (nl_first && line_reg != LN_MAX) line_next = line_reg + 1'b1;

            if (idle_go)
            begin
                mode_next = stt_pkg::M_IDLE;
                case (char_byte)
                    8'h20, 8'h09, 8'h0D: ;
                    8'h0A: if (line_reg != LN_MAX) line_next = line_reg + 1'b1;
                    8'h23: begin begin_next = pos_reg; mode_next = stt_pkg::M_HASH1; end
                    8'h40: begin begin_next = pos_reg; mode_next = stt_pkg::M_BUILTIN; end
                    8'h22: begin begin_next = pos_reg; mode_next = stt_pkg::M_STRING; end
                    8'h2D: begin begin_next = pos_reg; mode_next = stt_pkg::M_MINUS; end
                    8'h2E: begin begin_next = pos_reg; mode_next = stt_pkg::M_DOT; end
                    8'h28: begin e1 = 1'b1; c1.kind = stt_pkg::K_LPAREN; end
                    8'h29: begin e1 = 1'b1; c1.kind = stt_pkg::K_RPAREN; end
                    8'h7B: begin e1 = 1'b1; c1.kind = stt_pkg::K_LBRACE; end
                    8'h7D: begin e1 = 1'b1; c1.kind = stt_pkg::K_RBRACE; end
                    8'h2C: begin e1 = 1'b1; c1.kind = stt_pkg::K_COMMA; end
                    8'h3B: begin e1 = 1'b1; c1.kind = stt_pkg::K_SEMICOLON; end
                    8'h3A: begin e1 = 1'b1; c1.kind = stt_pkg::K_COLON; end
                    8'h3D: begin e1 = 1'b1; c1.kind = stt_pkg::K_EQUAL; end
                    8'h26: begin e1 = 1'b1; c1.kind = stt_pkg::K_AMP; end
                    8'h2A: begin e1 = 1'b1; c1.kind = stt_pkg::K_STAR; end
                    8'h2B: begin e1 = 1'b1; c1.kind = stt_pkg::K_PLUS; end
                    8'h2F: begin e1 = 1'b1; c1.kind = stt_pkg::K_SLASH; end
                    8'h25: begin e1 = 1'b1; c1.kind = stt_pkg::K_PERCENT; end
                    default:
                    begin
                        begin_next = pos_reg;
                        if (alpha)
                        begin
                            word_next = 64'(char_byte);
                            mode_next = stt_pkg::M_IDENT;
                        end
                        else if (digit) mode_next = stt_pkg::M_NUMBER;
                        else
                        begin
                            e1 = 1'b1; c1.kind = stt_pkg::K_ERROR;
                            c1.err = stt_pkg::E_BADCHAR;
                        end
                    end
                endcase
            end
        end
    end

    // Pack the slots so the first present token sits in slot 0
    always_comb
    begin
        n_tok = {1'b0, e0} + {1'b0, e1};
        ctl1 = c1;
        ctl1.last = 1'b1;
        start1 = s1;
        len1 = l1;
        if (e0)
        begin
            ctl0 = c0; ctl0.last = !e1; start0 = s0; len0 = l0;
        end
        else
        begin
            ctl0 = c1; ctl0.last = 1'b1; start0 = s1; len0 = l1;
        end
        // a flushed token sees the line before the byte; own token sees after
        line_a = line_reg;
        line_b = line_next;
        if (!e0) line_a = line_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stt_pkg::M_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            line_reg  <= '0;
            word_reg  <= '0;
            open_reg  <= '0;
            close_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            begin_reg <= begin_next;
            line_reg  <= line_next;
            word_reg  <= word_next;
            open_reg  <= open_next;
            close_reg <= close_next;
            if (!end_marker && pos_reg != OFF_MAX) pos_reg <= pos_reg + 1'b1;
        end
    end

endmodule

// ===== rtl/stt_back.sv =====
// ----------------------------------------------------------------------------
// Tokenizer back end
// Token queue between scanner and output port; pushes up to two a cycle.
// ----------------------------------------------------------------------------
module stt_back #(
    parameter int OFFSET_BITS = 24,
    parameter int LINE_BITS   = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             push_n,
    input  stt_pkg::tok_ctl_t      ctl0,
    input  logic [OFFSET_BITS-1:0] start0,
    input  logic [OFFSET_BITS-1:0] len0,
    input  logic [LINE_BITS-1:0]   line0,
    input  stt_pkg::tok_ctl_t      ctl1,
    input  logic [OFFSET_BITS-1:0] start1,
    input  logic [OFFSET_BITS-1:0] len1,
    input  logic [LINE_BITS-1:0]   line1,
    output logic                   room,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output stt_pkg::tok_ctl_t      m_ctl,
    output logic [OFFSET_BITS-1:0] m_start,
    output logic [OFFSET_BITS-1:0] m_len,
    output logic [LINE_BITS-1:0]   m_line
);

    localparam int EW    = 10 + 2 * OFFSET_BITS + LINE_BITS;
    localparam int DEPTH = 4;

    logic [EW-1:0] q_reg [DEPTH];
    logic [1:0]    rd_reg, wr_reg;
    logic [2:0]    cnt_reg, cnt_next;
    logic          pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = cnt_reg != 3'd0;
    assign room     = cnt_reg <= 3'd2;
    assign {m_ctl, m_start, m_len, m_line} = q_reg[rd_reg];
    assign cnt_next = cnt_reg + 3'(push_n) - {2'b00, pop};

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            q_reg[wr_reg] <= {ctl0, start0, len0, line0};
        if (push_n == 2'd2)
            q_reg[wr_reg + 2'd1] <= {ctl1, start1, len1, line1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_reg + {1'b0, pop};
            wr_reg  <= wr_reg + push_n;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/source_text_tokenizer_top.sv =====
// Output: a token is written into the token queue as the byte that completes it is accepted.
// Throughput: one byte per cycle while the four-word token queue has room
// for two more words; a byte yields at most two tokens.
// Reset: rst_n asynchronous, active low; clears scanner state and the queue.
// ----------------------------------------------------------------------------
// Source text tokenizer top level
// Byte stream in, token stream out.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top #(
    parameter int OFFSET_BITS = 24,
    parameter int LINE_BITS   = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_byte
    input  logic        s_tlast,   // end_marker
    output logic        m_tvalid,
    input  logic        m_tready,
    // token_kind[5:0], start_offset, token_length, line_number, error_code, zero fill
    output logic [((6 + 2 * OFFSET_BITS + LINE_BITS + 3 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic        m_tlast    // last_of_run
);

    localparam int DW = 6 + 2 * OFFSET_BITS + LINE_BITS + 3;
    localparam int TW = ((DW + 7) / 8) * 8;

    logic [1:0]             n_tok;
    stt_pkg::tok_ctl_t      ctl0, ctl1, m_ctl;
    logic [OFFSET_BITS-1:0] start0, len0, start1, len1, m_start, m_len;
    logic [LINE_BITS-1:0]   line_a, line_b, m_line;
    logic                   room, step;

    assign s_tready = room;
    assign step     = s_tvalid && room;

    stt_front #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_front (
        .clk, .rst_n, .step,
        .char_byte (s_tdata),
        .end_marker(s_tlast),
        .n_tok, .ctl0, .start0, .len0, .ctl1, .start1, .len1, .line_a, .line_b
    );

    stt_back #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_back (
        .clk, .rst_n,
        .push_n(step ? n_tok : 2'd0),
        .ctl0, .start0, .len0, .line0(line_a),
        .ctl1, .start1, .len1, .line1(line_b),
        .room, .m_tvalid, .m_tready, .m_ctl, .m_start, .m_len, .m_line
    );

    assign m_tdata = TW'({m_ctl.err, m_line, m_len, m_start, m_ctl.kind});
    assign m_tlast = m_ctl.last;

endmodule

// ===== rtl/stt_checker.sv =====
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Watches the top level's ports over time.
// ----------------------------------------------------------------------------
module stt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [5:0]  kind,
    input logic        m_tlast
);

    // hold the kind and last flag of the output word while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(kind) && $stable(m_tlast))
        else $error("output word changed under stall");

    // an accepted end marker is always followed by a valid output word
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no token after end marker");

    // end token is always the last of its run
    a_endlast: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && kind == stt_pkg::K_END |-> m_tlast)
        else $error("end token not last");

    // the unused kind between keywords and error, and any kind above end, is never produced
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> kind != (stt_pkg::K_ERROR - 6'd1) && kind <= stt_pkg::K_END)
        else $error("bad token kind");

endmodule

bind source_text_tokenizer_top stt_checker u_chk (
    .clk, .rst_n, .s_tvalid, .s_tready, .s_tlast, .m_tvalid, .m_tready,
    .kind(m_tdata[5:0]), .m_tlast
);

// ===== test/source_text_tokenizer_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Source text tokenizer testbench
// Feeds directed and random source text, byte by byte with end markers, and
// checks every token against a predictor of the scanner kept in a scoreboard.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top_test;

    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 20;
    localparam int DATA_W      = ((6 + 2 * OFFSET_BITS + LINE_BITS + 3 + 7) / 8) * 8;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_TOP = '1;
    localparam int NUM_ITEMS  = 310;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 150;

    typedef struct packed {
        logic [5:0]             kind;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] len;
        logic [LINE_BITS-1:0]   line;
        logic [2:0]             err;
        logic                   last;
    } token_t;

    class token_scoreboard;
        token_t                 tokens_due[$];
        token_t                 step_toks[$];
        int                     errors;
        stt_pkg::mode_t         mode;
        logic [OFFSET_BITS-1:0] pos;
        logic [OFFSET_BITS-1:0] tok_begin;
        logic [LINE_BITS-1:0]   line_cnt;
        logic [63:0]            prefix;
        logic [7:0]             open_cnt;
        logic [7:0]             close_cnt;
        string                  keywords[22];

        function new();
            keywords = '{"fun", "if", "else", "for", "return", "break", "continue",
                         "val", "var", "type", "and", "or", "i8", "i16", "i32",
                         "i64", "u8", "u16", "u32", "u64", "f32", "f64"};
            errors    = 0;
            mode      = stt_pkg::M_IDLE;
            pos       = '0;
            tok_begin = '0;
            line_cnt  = '0;
            prefix    = '0;
            open_cnt  = '0;
            close_cnt = '0;
        endfunction

        function void emit(logic [5:0] kind, logic [OFFSET_BITS-1:0] start,
                           logic [OFFSET_BITS-1:0] len, logic [2:0] err);
            token_t t;
            t.kind  = kind;
            t.start = start;
            t.len   = len;
            t.line  = line_cnt;
            t.err   = err;
            t.last  = 1'b0;
            step_toks.push_back(t);
        endfunction

        function logic [OFFSET_BITS-1:0] len_before();
            return (pos >= tok_begin) ? pos - tok_begin : '0;
        endfunction

        function logic [OFFSET_BITS-1:0] len_with();
            logic [OFFSET_BITS-1:0] d;
            d = len_before();
            return (d == OFF_MAX) ? OFF_MAX : d + 1'b1;
        endfunction

        function void bump_line();
            if (line_cnt != LINE_TOP)
                line_cnt++;
        endfunction

        function logic [5:0] word_kind();
            logic [63:0] packed_kw;
            for (int i = 0; i < 22; i++)
            begin
                packed_kw = '0;
                for (int j = 0; j < keywords[i].len(); j++)
                    packed_kw |= 64'(keywords[i][j]) << (8 * j);
                if (len_before() == keywords[i].len() && packed_kw == prefix)
                    return stt_pkg::K_NUMBER + 6'd1 + 6'(i);
            end
            return stt_pkg::K_IDENT;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void start_token(logic [7:0] c);
            logic [5:0] kind;
            bit         punct;
            mode  = stt_pkg::M_IDLE;
            punct = 1'b1;
            kind  = '0;
            case (c)
                " ", "\t", 8'h0d: return;
                "\n": begin bump_line(); return; end
                "#": begin tok_begin = pos; mode = stt_pkg::M_HASH1; return; end
                "@": begin tok_begin = pos; mode = stt_pkg::M_BUILTIN; return; end
                8'h22: begin tok_begin = pos; mode = stt_pkg::M_STRING; return; end
                "-": begin tok_begin = pos; mode = stt_pkg::M_MINUS; return; end
                ".": begin tok_begin = pos; mode = stt_pkg::M_DOT; return; end
                "(": kind = stt_pkg::K_LPAREN;
                ")": kind = stt_pkg::K_RPAREN;
                "{": kind = stt_pkg::K_LBRACE;
                "}": kind = stt_pkg::K_RBRACE;
                ",": kind = stt_pkg::K_COMMA;
                ";": kind = stt_pkg::K_SEMICOLON;
                ":": kind = stt_pkg::K_COLON;
                "=": kind = stt_pkg::K_EQUAL;
                "&": kind = stt_pkg::K_AMP;
                "*": kind = stt_pkg::K_STAR;
                "+": kind = stt_pkg::K_PLUS;
                "/": kind = stt_pkg::K_SLASH;
                "%": kind = stt_pkg::K_PERCENT;
                default: punct = 1'b0;
            endcase
            if (punct)
            begin
                emit(kind, pos, 1, stt_pkg::E_NONE);
                return;
            end
            tok_begin = pos;
            if (is_alpha(c))
            begin
                prefix = 64'(c);
                mode   = stt_pkg::M_IDENT;
            end
            else if (is_digit(c))
                mode = stt_pkg::M_NUMBER;
            else
                emit(stt_pkg::K_ERROR, pos, 1, stt_pkg::E_BADCHAR);
        endfunction

        function void end_of_source();
            case (mode)
                stt_pkg::M_IDENT:
                    emit(word_kind(), tok_begin, len_before(), stt_pkg::E_NONE);
                stt_pkg::M_BUILTIN:
                    emit(stt_pkg::K_BUILTIN, tok_begin, len_before(), stt_pkg::E_NONE);
                stt_pkg::M_NUMBER, stt_pkg::M_FRAC:
                    emit(stt_pkg::K_NUMBER, tok_begin, len_before(), stt_pkg::E_NONE);
                stt_pkg::M_NUMDOT:
                    emit(stt_pkg::K_ERROR, tok_begin, len_before(), stt_pkg::E_DOT);
                stt_pkg::M_STRING:
                    emit(stt_pkg::K_ERROR, tok_begin, len_before(), stt_pkg::E_STRING);
                stt_pkg::M_MINUS:
                    emit(stt_pkg::K_MINUS, tok_begin, len_before(), stt_pkg::E_NONE);
                stt_pkg::M_DOT:
                    emit(stt_pkg::K_DOT, tok_begin, len_before(), stt_pkg::E_NONE);
                stt_pkg::M_OPEN, stt_pkg::M_BODY:
                    emit(stt_pkg::K_ERROR, tok_begin, len_before(), stt_pkg::E_COMMENT);
                stt_pkg::M_CLOSE:
                    if (close_cnt != open_cnt)
                        emit(stt_pkg::K_ERROR, tok_begin, len_before(),
                             stt_pkg::E_COMMENT);
                default: ;
            endcase
            emit(stt_pkg::K_END, pos, 0, stt_pkg::E_NONE);
            mode = stt_pkg::M_IDLE;
        endfunction

        function void scan(logic [7:0] c);
            bit word;
            word = is_alpha(c) || is_digit(c);
            case (mode)
                stt_pkg::M_HASH1:
                    if (c == "#") begin open_cnt = 2; mode = stt_pkg::M_OPEN; end
                    else if (c == "\n") start_token(c);
                    else mode = stt_pkg::M_LINE;
                stt_pkg::M_LINE:
                    if (c == "\n") start_token(c);
                stt_pkg::M_OPEN:
                    if (c == "#")
                    begin
                        if (open_cnt != 8'd255) open_cnt++;
                    end
                    else
                    begin
                        mode = stt_pkg::M_BODY;
                        if (c == "\n") bump_line();
                    end
                stt_pkg::M_BODY:
                    if (c == "#") begin close_cnt = 1; mode = stt_pkg::M_CLOSE; end
                    else if (c == "\n") bump_line();
                stt_pkg::M_CLOSE:
                    if (c == "#")
                    begin
                        if (close_cnt != 8'd255) close_cnt++;
                    end
                    else if (close_cnt == open_cnt)
                        start_token(c);
                    else
                    begin
                        mode = stt_pkg::M_BODY;
                        if (c == "\n") bump_line();
                    end
                stt_pkg::M_IDENT:
                    if (word)
                    begin
                        if (len_before() < stt_pkg::KW_CHARS)
                            prefix |= 64'(c) << (8 * len_before());
                    end
                    else
                    begin
                        emit(word_kind(), tok_begin, len_before(), stt_pkg::E_NONE);
                        start_token(c);
                    end
                stt_pkg::M_BUILTIN:
                    if (!word)
                    begin
                        emit(stt_pkg::K_BUILTIN, tok_begin, len_before(), stt_pkg::E_NONE);
                        start_token(c);
                    end
                stt_pkg::M_NUMBER:
                    if (c == ".") mode = stt_pkg::M_NUMDOT;
                    else if (!is_digit(c))
                    begin
                        emit(stt_pkg::K_NUMBER, tok_begin, len_before(), stt_pkg::E_NONE);
                        start_token(c);
                    end
                stt_pkg::M_NUMDOT:
                    if (is_digit(c)) mode = stt_pkg::M_FRAC;
                    else
                    begin
                        emit(stt_pkg::K_ERROR, tok_begin, len_before(), stt_pkg::E_DOT);
                        start_token(c);
                    end
                stt_pkg::M_FRAC:
                    if (!is_digit(c))
                    begin
                        emit(stt_pkg::K_NUMBER, tok_begin, len_before(), stt_pkg::E_NONE);
                        start_token(c);
                    end
                stt_pkg::M_STRING:
                    if (c == 8'h22)
                    begin
                        emit(stt_pkg::K_STRING, tok_begin, len_with(), stt_pkg::E_NONE);
                        mode = stt_pkg::M_IDLE;
                    end
                    else if (c == "\n") bump_line();
                stt_pkg::M_MINUS:
                    if (c == ">")
                    begin
                        emit(stt_pkg::K_ARROW, tok_begin, len_with(), stt_pkg::E_NONE);
                        mode = stt_pkg::M_IDLE;
                    end
                    else
                    begin
                        emit(stt_pkg::K_MINUS, tok_begin, len_before(), stt_pkg::E_NONE);
                        start_token(c);
                    end
                stt_pkg::M_DOT:
                    if (c == "*")
                    begin
                        emit(stt_pkg::K_DOTSTAR, tok_begin, len_with(), stt_pkg::E_NONE);
                        mode = stt_pkg::M_IDLE;
                    end
                    else
                    begin
                        emit(stt_pkg::K_DOT, tok_begin, len_before(), stt_pkg::E_NONE);
                        start_token(c);
                    end
                default: start_token(c);
            endcase
        endfunction

        function void note_input(logic [7:0] c, logic eos);
            step_toks.delete();
            if (eos)
                end_of_source();
            else
            begin
                scan(c);
                if (pos != OFF_MAX) pos++;
            end
            if (step_toks.size() > 0)
                step_toks[step_toks.size() - 1].last = 1'b1;
            foreach (step_toks[i])
                tokens_due.push_back(step_toks[i]);
        endfunction

        function void check_token(logic [DATA_W-1:0] data, logic last);
            token_t e;
            token_t a;
            a.kind  = data[5:0];
            a.start = data[6 +: OFFSET_BITS];
            a.len   = data[6 + OFFSET_BITS +: OFFSET_BITS];
            a.line  = data[6 + 2 * OFFSET_BITS +: LINE_BITS];
            a.err   = data[6 + 2 * OFFSET_BITS + LINE_BITS +: 3];
            a.last  = last;
            if (tokens_due.size() == 0)
            begin
                $display("%0t: unexpected token kind %0d start %0d", $time, a.kind, a.start);
                errors++;
                return;
            end
            e = tokens_due.pop_front();
            if (a.kind != e.kind)
                begin $display("%0t: kind exp %0d got %0d", $time, e.kind, a.kind); errors++; end
            if (a.start != e.start)
                begin $display("%0t: start exp %0d got %0d", $time, e.start, a.start); errors++; end
            if (a.len != e.len)
                begin $display("%0t: length exp %0d got %0d", $time, e.len, a.len); errors++; end
            if (a.line != e.line)
                begin $display("%0t: line exp %0d got %0d", $time, e.line, a.line); errors++; end
            if (a.err != e.err)
                begin $display("%0t: error exp %0d got %0d", $time, e.err, a.err); errors++; end
            if (a.last != e.last)
                begin $display("%0t: last exp %0d got %0d", $time, e.last, a.last); errors++; end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;

    token_scoreboard sb;
    bit              hold_req;
    int              idle_cycles;
    int              bytes_sent;
    int              burst_left;

    source_text_tokenizer_top #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_token(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver: steps through random stall styles (always ready, a fixed pattern, random); long hold when asked
    initial
    begin
        int stall_style;
        stall_style = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            for (int i = 0; i < 64; i++)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    m_tready <= 1'b0;
                    repeat (HOLD_LEN) @(posedge clk);
                    hold_req = 1'b0;
                end
                case (stall_style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= (i % 5) != 2 && (i % 7) != 4;
                    default: m_tready <= ($urandom_range(0, 1) == 1);
                endcase
            end
            stall_style = $urandom_range(0, 2);
        end
    end

    // Offer one byte; bursts of random length with random gaps between
    task automatic send_byte(input logic [7:0] c, input logic eos);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], 1'b0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.tokens_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic string rand_word(input int n);
        string w;
        string alnum;
        alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        w = "";
        for (int i = 0; i < n; i++)
            w = {w, string'(alnum[$urandom_range(0, i == 0 ? 52 : 62)])};
        return w;
    endfunction

    function automatic string rand_digits();
        string d;
        d = "";
        repeat ($urandom_range(1, 3))
            d = {d, string'(8'($urandom_range("0", "9")))};
        return d;
    endfunction

    task automatic send_snippet();
        string kw[22];
        string ws;
        int    n;
        kw = '{"fun", "if", "else", "for", "return", "break", "continue", "val", "var",
               "type", "and", "or", "i8", "i16", "i32", "i64", "u8", "u16", "u32", "u64",
               "f32", "f64"};
        ws = " \t\r\n";
        case ($urandom_range(0, 15))
            0:  send_text(kw[$urandom_range(0, 21)]);
            1:  send_text(rand_word($urandom_range(1, 11)));
            2:  send_text({"@", rand_word($urandom_range(0, 5))});
            3:  send_text({rand_digits(), ".", rand_digits()});
            4:  send_text(rand_digits());
            5:  send_text({rand_digits(), "."});
            6:  send_text({"\"", rand_word($urandom_range(0, 4)), "\n", "x\""});
            7:  send_text($urandom_range(0, 1) ? "->" : ".*");
            8:  send_text($urandom_range(0, 1) ? "-" : ".");
            9:  send_text("# note ## x\n");
            10:
                if ($urandom_range(0, 1))
                    send_text("## a\n# ### b ##");
                else
                    send_text("## a\n# ### b ###");
            11: send_text("(){},;:=&*+/%");
            12: send_byte(8'($urandom_range(0, 255)), 1'b0);
            13: send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            14: send_byte(8'h00, 1'b1);
            default: ;
        endcase
        n = $urandom_range(0, 2);
        repeat (n)
            send_byte(ws[$urandom_range(0, 3)], 1'b0);
    endtask

    initial
    begin
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        rst_n       = 1'b0;
        hold_req    = 1'b0;
        idle_cycles = 0;
        bytes_sent  = 0;
        burst_left  = 0;
        sb          = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: many token shapes, every error code, both extremes of the byte
        send_text("fun(a){x=1.5;}->.*@b\"s\n\"3.y");
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_text("## c\n##");
        send_byte(8'h00, 1'b1);
        send_text("\"open");
        send_byte(8'hff, 1'b1);
        send_text("### x ##");
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b1);
        drain();

        // Long receiver hold while the sender keeps offering
        hold_req = 1'b1;
        repeat (40) send_text("(,");

        while (bytes_sent < NUM_ITEMS)
        begin
            send_snippet();
            if ($urandom_range(0, 40) == 0)
                drain();
        end
        send_byte(8'h00, 1'b1);
        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.tokens_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
